/* src/dfq_pkg.sv */
package dfq_pkg;

    localparam int ID_W        = 31;
    localparam int OCC_W       = 11;
    localparam int STATUS_W    = 3;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;
    localparam int DEPTH_DEF   = 1024;

    // OR tree fan-in per registered level
    localparam int FANIN_LOG = 5;
    localparam int FANIN     = 1 << FANIN_LOG;

    typedef enum logic [STATUS_W-1:0] {
        ST_PUT_OK = 3'd0,
        ST_FULL   = 3'd1,
        ST_DUP    = 3'd2,
        ST_GOT    = 3'd3,
        ST_EMPTY  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_COMMIT
    } t_state;

    // broadcast to every cell
    typedef struct packed {
        logic            cmp;    // latch match against id
        logic            load;   // first empty cell takes id
        logic            shift;  // pop: every cell takes its upper neighbor
        logic [ID_W-1:0] id;
    } t_cell_ctl;

    // number of bits left after k levels of FANIN-wide reduction
    function automatic int tree_width(input int d, input int k);
        return (d + (1 << (FANIN_LOG * k)) - 1) >> (FANIN_LOG * k);
    endfunction

    function automatic int tree_levels(input int d);
        int w;
        int l;
        w = d;
        l = 0;
        for (int i = 0; i < 8; i++) begin
            if (w > 1) begin
                w = (w + FANIN - 1) >> FANIN_LOG;
                l = l + 1;
            end
        end
        return (l < 1) ? 1 : l;
    endfunction

endpackage

/* src/dfq_cell.sv */
module dfq_cell
    import dfq_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cell_ctl       i_ctl,
    input  logic            i_prev_valid,   // cell toward the head
    input  logic            i_next_valid,   // cell toward the tail
    input  logic [ID_W-1:0] i_next_id,
    output logic            o_valid,
    output logic [ID_W-1:0] o_id,
    output logic            o_match
);

    logic            r_valid;
    logic [ID_W-1:0] r_id;
    logic            r_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_next_valid;
        end else if (i_ctl.load && !r_valid && i_prev_valid) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_id <= i_next_id;
        end else if (i_ctl.load && !r_valid && i_prev_valid) begin
            r_id <= i_ctl.id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_match <= r_valid && (r_id == i_ctl.id);
        end
    end

    assign o_valid = r_valid;
    assign o_id    = r_id;
    assign o_match = r_match;

endmodule

/* src/dfq_or_tree.sv */
module dfq_or_tree
    import dfq_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int LEVELS = tree_levels(DEPTH)
) (
    input  logic             i_clk,
    input  logic [DEPTH-1:0] i_bits,
    output logic             o_any
);

    logic [LEVELS:0][DEPTH-1:0] w_lvl;
    logic [LEVELS:1][DEPTH-1:0] n_lvl;
    logic [LEVELS:1][DEPTH-1:0] r_lvl;

    assign w_lvl[0] = i_bits;

    for (genvar k = 1; k <= LEVELS; k++) begin : g_lvl
        localparam int WP = tree_width(DEPTH, k - 1);
        localparam int WK = tree_width(DEPTH, k);

        assign w_lvl[k] = r_lvl[k];

        for (genvar j = 0; j < WK; j++) begin : g_grp
            localparam int LO = j * FANIN;
            localparam int N  = (WP - LO > FANIN) ? FANIN : (WP - LO);
            assign n_lvl[k][j] = |w_lvl[k-1][LO +: N];
        end

        if (WK < DEPTH) begin : g_pad
            assign n_lvl[k][DEPTH-1:WK] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl <= n_lvl;
    end

    assign o_any = r_lvl[LEVELS][0];

endmodule

/* src/dedup_fifo_queue.sv */
// Duplicate-rejecting FIFO of 31-bit user ids.
//
// Slave channel (i_s_*): one request per transfer. tuser = mode (0 put, 1 get),
// tdata[30:0] = user_id. Master channel (o_m_*): one response per request, in
// order. tuser = status (put ok, full, duplicate, got id, empty),
// tdata = head_id and occupancy after the request.
//
// Storage is a row of QUEUE_DEPTH cells; cell 0 is the head. A put lands in the
// first empty cell, a get shifts every cell down by one. On acceptance each
// cell registers whether its id equals the incoming one; those match bits are
// OR-reduced by a registered tree, 32 inputs per level (2 levels at 1024).
// One request is in flight at a time: the match bits are registered, then each
// tree level, then the response register, and no new request is taken before
// the response is loaded, so throughput is set by the depth of the match tree.
//
// The response sits in an output register, so the next request is accepted
// while it waits. If the receiver stalls, the following request finishes its
// search and holds until the register frees. Reset (synchronous, active low)
// empties the queue and drops any pending response; no clearing pass needed.
module dedup_fifo_queue
    import dfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [30:0] user_id, [31] zero
    input  logic                   i_s_tuser,   // [0] mode
    // response
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // [30:0] head_id, [41:31] occupancy,
                                                // [47:42] zero
    output logic [STATUS_W-1:0]    o_m_tuser    // [2:0] status
);

    localparam int LEVELS = tree_levels(QUEUE_DEPTH);
    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PAD_W  = OUT_TDATA_W - ID_W - OCC_W;

    // control state
    t_state           r_state, n_state;
    logic [LW-1:0]    r_cnt, n_cnt;
    logic [CW-1:0]    r_count, n_count;
    logic             r_out_valid, n_out_valid;

    // held request and response payload
    logic             r_mode;
    logic [ID_W-1:0]  r_id;
    t_status          r_status, n_status;
    logic [ID_W-1:0]  r_head, n_head;
    logic [OCC_W-1:0] r_occ, n_occ;

    t_cell_ctl        w_ctl;
    logic             w_accept;
    logic             w_load_out;
    logic             w_any;
    logic [CW+OCC_W-1:0] w_occ_ext;

    logic [ID_W-1:0]        w_id [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_valid;
    logic [QUEUE_DEPTH-1:0] w_match;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // cell row
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic            w_prev_valid;
        logic            w_next_valid;
        logic [ID_W-1:0] w_next_id;

        if (i == 0) begin : g_head
            assign w_prev_valid = 1'b1;
        end else begin : g_mid
            assign w_prev_valid = w_valid[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign w_next_valid = 1'b0;
            assign w_next_id    = '0;
        end else begin : g_body
            assign w_next_valid = w_valid[i+1];
            assign w_next_id    = w_id[i+1];
        end

        dfq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_prev_valid (w_prev_valid),
            .i_next_valid (w_next_valid),
            .i_next_id    (w_next_id),
            .o_valid      (w_valid[i]),
            .o_id         (w_id[i]),
            .o_match      (w_match[i])
        );
    end

    // duplicate search over the registered match bits
    dfq_or_tree #(
        .DEPTH  (QUEUE_DEPTH),
        .LEVELS (LEVELS)
    ) u_or_tree (
        .i_clk  (i_clk),
        .i_bits (w_match),
        .o_any  (w_any)
    );

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_count     = r_count;
        n_status    = r_status;
        n_head      = r_head;
        w_load_out  = 1'b0;
        w_ctl.cmp   = 1'b0;
        w_ctl.load  = 1'b0;
        w_ctl.shift = 1'b0;
        w_ctl.id    = r_id;

        case (r_state)
            S_IDLE: begin
                w_ctl.id = i_s_tdata[ID_W-1:0];
                if (i_s_tvalid) begin
                    w_ctl.cmp = 1'b1;
                    n_cnt     = LW'(LEVELS - 1);
                    n_state   = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (r_cnt == '0) begin
                    n_state = S_COMMIT;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_COMMIT: begin
                // wait for the response register to free up
                if (!r_out_valid || i_m_tready) begin
                    w_load_out = 1'b1;
                    n_head     = '0;
                    n_state    = S_IDLE;
                    if (!r_mode) begin
                        if (r_count == CW'(QUEUE_DEPTH)) begin
                            n_status = ST_FULL;
                        end else if (w_any) begin
                            n_status = ST_DUP;
                        end else begin
                            n_status   = ST_PUT_OK;
                            w_ctl.load = 1'b1;
                            n_count    = r_count + 1'b1;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_status    = ST_GOT;
                            n_head      = w_id[0];
                            w_ctl.shift = 1'b1;
                            n_count     = r_count - 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // occupancy wraps to the field width for very deep queues
        w_occ_ext = {{OCC_W{1'b0}}, n_count};
        n_occ     = w_occ_ext[OCC_W-1:0];

        if (w_load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_s_tuser;
            r_id   <= i_s_tdata[ID_W-1:0];
        end
        if (w_load_out) begin
            r_status <= n_status;
            r_head   <= n_head;
            r_occ    <= n_occ;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_occ, r_head};
    assign o_m_tuser  = r_status;

endmodule

/* tb/dedup_fifo_queue_tb.sv */
module dedup_fifo_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dfq_pkg::*;

    // bench setup
    localparam int QUEUE_DEPTH    = DEPTH_DEF;
    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 9;
    localparam int MAX_GAP        = 6;
    localparam int DRAIN_CYCLES   = 20;    // pad generously past the match tree latency
    localparam int WATCHDOG_LIMIT = 2000;  // above the worst honest idle stretch
    localparam int MAX_REPORTS    = 10;

    localparam logic            MODE_PUT = 1'b0;
    localparam logic            MODE_GET = 1'b1;
    localparam logic [ID_W-1:0] ID_MAX   = {ID_W{1'b1}};

    typedef struct packed {
        t_status          status;
        logic [ID_W-1:0]  head_id;
        logic [OCC_W-1:0] occupancy;
    } t_resp;

    // one row of the directed table; resp is only meaningful when fixed is set
    typedef struct packed {
        logic            mode;
        logic [ID_W-1:0] user_id;
        logic            fixed;
        t_resp           resp;
    } t_dir_row;

    localparam int DIR_ROWS = 21;

    // Directed opening: empty get right after reset, both id extremes, duplicate
    // at the head and near the tail, reuse of a popped id, get ignoring its id.
    t_dir_row dir_table [DIR_ROWS] = '{
        '{MODE_GET, 31'd0,         1'b1, '{ST_EMPTY,  31'd0,         11'd0}},
        '{MODE_PUT, 31'd0,         1'b1, '{ST_PUT_OK, 31'd0,         11'd1}},
        '{MODE_PUT, 31'd0,         1'b1, '{ST_DUP,    31'd0,         11'd1}},
        '{MODE_PUT, ID_MAX,        1'b1, '{ST_PUT_OK, 31'd0,         11'd2}},
        '{MODE_PUT, ID_MAX,        1'b1, '{ST_DUP,    31'd0,         11'd2}},
        '{MODE_PUT, 31'h5555_5555, 1'b0, '0},
        '{MODE_PUT, 31'h2AAA_AAAA, 1'b0, '0},
        '{MODE_GET, ID_MAX,        1'b1, '{ST_GOT,    31'd0,         11'd3}},
        '{MODE_PUT, 31'd0,         1'b1, '{ST_PUT_OK, 31'd0,         11'd4}},
        '{MODE_PUT, 31'h2AAA_AAAA, 1'b1, '{ST_DUP,    31'd0,         11'd4}},
        '{MODE_GET, 31'd0,         1'b1, '{ST_GOT,    ID_MAX,        11'd3}},
        '{MODE_GET, 31'h1234_5678, 1'b0, '0},
        '{MODE_GET, ID_MAX,        1'b0, '0},
        '{MODE_GET, 31'd0,         1'b1, '{ST_GOT,    31'd0,         11'd0}},
        '{MODE_GET, ID_MAX,        1'b1, '{ST_EMPTY,  31'd0,         11'd0}},
        '{MODE_PUT, 31'd1,         1'b0, '0},
        '{MODE_PUT, 31'h4000_0000, 1'b0, '0},
        '{MODE_GET, 31'd1,         1'b0, '0},
        '{MODE_PUT, 31'd1,         1'b0, '0},
        '{MODE_GET, 31'd0,         1'b0, '0},
        '{MODE_GET, 31'd0,         1'b0, '0}
    };

    // DUT I/O, all driven from time zero
    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;   // [30:0] user_id, [31] zero
    logic                   i_s_tuser  = 1'b0; // [0] mode
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;         // [30:0] head_id, [41:31] occupancy
    logic [STATUS_W-1:0]    o_m_tuser;         // [2:0] status

    // predictor state: ids held, head first
    logic [ID_W-1:0] held_ids [$];
    t_resp           pending_responses [$];

    bit no_idle = 1'b0;   // both sides run back to back while set
    int mismatch_count = 0;
    int requests_sent  = 0;
    int idle_cycles    = 0;
    int peak_occupancy = 0;
    int status_seen [5] = '{default: 0};

    dedup_fifo_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        forever #(HALF_PERIOD) i_clk = ~i_clk;
    end

    // Queue behavior in bench terms: full check wins over duplicate check,
    // get on empty leaves state alone, head_id only nonzero on a pop.
    function automatic t_resp predict_response(input logic mode, input logic [ID_W-1:0] id);
        t_resp r;
        bit    seen;
        r = '0;
        seen = 1'b0;
        if (mode == MODE_PUT) begin
            if (held_ids.size() >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                foreach (held_ids[i]) begin
                    if (held_ids[i] == id) seen = 1'b1;
                end
                if (seen) begin
                    r.status = ST_DUP;
                end else begin
                    held_ids.insert(held_ids.size(), id);
                    r.status = ST_PUT_OK;
                end
            end
        end else if (held_ids.size() == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.head_id = held_ids[0];
            held_ids.delete(0);
            r.status  = ST_GOT;
        end
        r.occupancy = OCC_W'(held_ids.size());
        return r;
    endfunction

    // Drive one request from a falling edge, hold until taken, leave at the next
    // falling edge. tvalid is written once per edge, so a zero gap keeps it high.
    task automatic send_request(input logic mode, input logic [ID_W-1:0] id,
                                input logic fixed, input t_resp fixed_resp);
        int    gap;
        t_resp predicted;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = mode;
        i_s_tdata  = {1'b0, id};
        do @(posedge i_clk); while (!o_s_tready);
        // taken at this edge; predictor must still run to keep its state in step
        predicted = predict_response(mode, id);
        pending_responses.insert(pending_responses.size(), fixed ? fixed_resp : predicted);
        requests_sent++;
        @(negedge i_clk);
    endtask

    // Random request. put_pct biases the mode; held_pct is the chance of
    // reusing an id already queued (duplicate, or full-vs-dup precedence);
    // pool_ids narrows fresh ids to a few values near both extremes.
    task automatic random_request(input int put_pct, input int held_pct, input bit pool_ids);
        logic            mode;
        logic [ID_W-1:0] id;
        logic [3:0]      sel;
        mode = ($urandom_range(1, 100) <= put_pct) ? MODE_PUT : MODE_GET;
        sel  = 4'($urandom_range(0, 15));
        if (held_ids.size() != 0 && $urandom_range(1, 100) <= held_pct) begin
            id = held_ids[$urandom_range(0, held_ids.size() - 1)];
        end else if (pool_ids) begin
            id = sel[3] ? ID_MAX - ID_W'(sel[2:0]) : ID_W'(sel[2:0]);
        end else begin
            id = ID_W'($urandom());
        end
        send_request(mode, id, 1'b0, '0);
    endtask

    // Stimulus: reset, directed table, then phases that walk the queue from
    // empty through full and back down.
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_table[r]) begin
            send_request(dir_table[r].mode, dir_table[r].user_id,
                         dir_table[r].fixed, dir_table[r].resp);
        end

        // low occupancy churn on a tiny id pool: lots of dups and empty gets
        for (int k = 0; k < 30; k++) begin
            no_idle = (k < 12);
            random_request(50, 20, 1'b1);
        end

        // fill to the brim; one stretch runs with no idling at all
        while (held_ids.size() < QUEUE_DEPTH) begin
            no_idle = (held_ids.size() >= 300 && held_ids.size() < 500);
            random_request(99, 2, 1'b0);
        end
        no_idle = 1'b0;

        // puts against a full queue, some of them with ids already held
        repeat (15) random_request(100, 40, 1'b0);

        // mostly pops, with the odd put refilling a freed slot
        repeat (20) random_request(5, 30, 1'b0);

        // mixed tail, pool ids plus reuse
        repeat (20) random_request(40, 25, 1'b1);

        i_s_tvalid = 1'b0;

        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests: %0d puts taken, %0d full drops, %0d duplicate drops,",
                 requests_sent, status_seen[ST_PUT_OK], status_seen[ST_FULL],
                 status_seen[ST_DUP]);
        $display("  %0d ids popped, %0d empty gets, peak occupancy %0d of %0d",
                 status_seen[ST_GOT], status_seen[ST_EMPTY], peak_occupancy, QUEUE_DEPTH);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Response side: random stall per response, released during no_idle stretches.
    initial begin
        int stall;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (stall != 0) begin
                i_m_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            @(negedge i_clk);
        end
    end

    // Scoreboard: every response against the oldest pending prediction.
    always @(posedge i_clk) begin
        t_resp got;
        t_resp want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.status    = t_status'(o_m_tuser);
            got.head_id   = o_m_tdata[ID_W-1:0];
            got.occupancy = o_m_tdata[ID_W +: OCC_W];
            if (int'(got.status) < 5) status_seen[got.status]++;
            if (int'(got.occupancy) > peak_occupancy) peak_occupancy = int'(got.occupancy);
            if (pending_responses.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: response with nothing pending: status %0d head %h occ %0d",
                             $realtime, got.status, got.head_id, got.occupancy);
            end else begin
                want = pending_responses[0];
                pending_responses.delete(0);
                if (got.status != want.status || got.head_id != want.head_id ||
                    got.occupancy != want.occupancy) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"%0t: mismatch: want status %0d head %h occ %0d,",
                                  " got status %0d head %h occ %0d"},
                                 $realtime, want.status, want.head_id, want.occupancy,
                                 got.status, got.head_id, got.occupancy);
                end
            end
        end
    end

    // Watchdog: too long with no transfer on either channel means a hang.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Stalled for %0d cycles with %0d responses pending",
                     idle_cycles, pending_responses.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
